FILE: design/slu_pkg.sv
// Package for the sorted unique line set: sizes, request and status codes,
// and the structs passed between the top level and its insertion cells.
// No dependencies.
`default_nettype none

package slu_pkg;

   localparam int CAPACITY  = 64;
   localparam int LINE_BITS = 20;
   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int INDEX_W   = $clog2(CAPACITY);

   typedef logic [LINE_BITS-1:0] slu_line_type;
   typedef logic [COUNT_W-1:0]   slu_count_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } slu_req_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_FULL    = 3'd2,
      ST_INVALID = 3'd3,
      ST_RANGE   = 3'd4
   } slu_status_type;

   // broadcast to every cell
   typedef struct packed {
      logic         shift_en;
      slu_line_type line;
   } slu_bcast_type;

   // handed from one cell to the next
   typedef struct packed {
      slu_line_type entry;
      logic         lt;
   } slu_link_type;

endpackage

`default_nettype wire

FILE: design/slu_cell.sv
// One cell of the insertion chain: holds one sorted entry, compares it with
// the broadcast line and takes the new line or its left neighbor on insert.
// Depends on slu_pkg.
`default_nettype none

module slu_cell
   import slu_pkg::*;
(
   input  wire logic          clock,
   input  wire slu_bcast_type bcast,
   input  wire logic          occupied,
   input  wire slu_link_type  prev,
   output slu_link_type       self,
   output logic               hit
);

   slu_line_type entry_ff;
   slu_line_type entry_in;

   assign self.entry = entry_ff;
   assign self.lt    = occupied && (entry_ff < bcast.line);
   assign hit        = occupied && (entry_ff == bcast.line);

   always_comb begin
      entry_in = entry_ff;
      if (bcast.shift_en && !self.lt) begin
         entry_in = prev.lt ? bcast.line : prev.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: design/sorted_unique_line_set.sv
// Top level of the sorted unique line set: a chain of insertion cells plus
// request decode, count register and registered response.
// Depends on slu_pkg and slu_cell.
//
// Usage: a request (insert, clear or read) is taken at a rising edge where
// start is high and busy is low. busy stays low, so a request may be issued
// every cycle. Each request gives exactly one response, on the rsp_ ports
// with rsp_valid high for one cycle, in the cycle after the request, at a
// throughput of one request per cycle. An insert compares the line against
// all held entries at once in the cell chain; the cell at the insert point
// takes the new line and every cell above it takes its left neighbor's entry
// in the same edge. A read selects the entry at req_read_index from the
// chain. Responses cannot be held off by the receiver; each is shown for
// one cycle only. Reset (synchronous, active high) empties the set and drops
// any pending response; entry storage is not cleared, since slots at or
// above the count are never read.
`default_nettype none

module sorted_unique_line_set
   import slu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [19:0] req_line_number,
   input  wire logic [5:0]  req_read_index,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [19:0]      rsp_entry_line,
   output logic [6:0]       rsp_entry_count,
   output logic             rsp_set_empty
);

   slu_count_type  held_count_ff, held_count_in;
   logic           rsp_valid_ff;
   slu_status_type rsp_status_ff, rsp_status_in;
   slu_line_type   rsp_line_ff, rsp_line_in;

   slu_bcast_type          bcast;
   slu_link_type           link [CAPACITY+1];
   logic [CAPACITY-1:0]    hit;
   logic [CAPACITY-1:0]    occupied;
   slu_req_type            req;
   logic                   accept;
   logic                   is_dup;
   logic                   is_full;
   logic                   is_zero;
   logic                   ins_ok;
   logic [INDEX_W-1:0]     rd_idx;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign req     = slu_req_type'(req_type);
   assign rd_idx  = req_read_index[INDEX_W-1:0];

   assign bcast.line     = req_line_number[LINE_BITS-1:0];
   assign is_dup         = |hit;
   assign is_full        = (held_count_ff == COUNT_W'(CAPACITY));
   assign is_zero        = (bcast.line == '0);
   assign ins_ok         = accept && (req == REQ_INSERT) && !is_zero && !is_dup && !is_full;
   assign bcast.shift_en = ins_ok;

   assign link[0].entry = '0;
   assign link[0].lt    = 1'b1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (COUNT_W'(i) < held_count_ff);
      slu_cell u_cell (
         .clock    (clock),
         .bcast    (bcast),
         .occupied (occupied[i]),
         .prev     (link[i]),
         .self     (link[i+1]),
         .hit      (hit[i])
      );
   end

   always_comb begin
      held_count_in = held_count_ff;
      rsp_status_in = ST_OK;
      rsp_line_in   = '0;
      unique case (req)
         REQ_INSERT: begin
            if (is_zero) begin
               rsp_status_in = ST_INVALID;
            end else if (is_dup) begin
               rsp_status_in = ST_DUP;
            end else if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               held_count_in = held_count_ff + 1'b1;
            end
         end
         REQ_CLEAR: begin
            held_count_in = '0;
         end
         REQ_READ: begin
            if (COUNT_W'(rd_idx) < held_count_ff) begin
               rsp_line_in = link[COUNT_W'(rd_idx) + 1'b1].entry;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            held_count_ff <= held_count_in;
         end
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_line_ff   <= rsp_line_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_line  = 20'(rsp_line_ff);
   assign rsp_entry_count = 7'(held_count_ff);
   assign rsp_set_empty   = (held_count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= COUNT_W'(CAPACITY))
      else $error("count above capacity");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request without response");

   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without request");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> held_count_ff == $past(held_count_ff) + 1'b1)
      else $error("insert did not grow count");

   a_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_entry_line == '0)
      else $error("entry line set on failed request");

endmodule

`default_nettype wire

FILE: tb/sorted_unique_line_set_test.sv
`timescale 1ns / 1ps
// Self-checking test of sorted_unique_line_set: drives insert, clear and read
// requests, predicts each response from a shadow copy of the set and checks it.
// Depends on slu_pkg and the sorted_unique_line_set RTL.

module sorted_unique_line_set_test
   import slu_pkg::*;
();

   typedef struct packed {
      logic [2:0]    status;
      slu_line_type  line;
      slu_count_type count;
      logic          empty;
   } line_set_result_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [1:0]    req_type;
   logic [19:0]   req_line_number;
   logic [5:0]    req_read_index;
   logic          rsp_valid;
   logic [2:0]    rsp_status;
   logic [19:0]   rsp_entry_line;
   logic [6:0]    rsp_entry_count;
   logic          rsp_set_empty;

   line_set_result_type results_due[$];
   slu_line_type        shadow_lines[$];
   int                  error_count = 0;
   int                  burst_left  = 0;

   sorted_unique_line_set dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_line_number (req_line_number),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_line  (rsp_entry_line),
      .rsp_entry_count (rsp_entry_count),
      .rsp_set_empty   (rsp_set_empty)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("sorted_unique_line_set_test: FAIL");
      $finish;
   end

   // updates the shadow set and returns the response the request must give
   function automatic line_set_result_type predict_line_set(slu_req_type kind,
                                                            slu_line_type line,
                                                            logic [5:0] idx);
      line_set_result_type r;
      int pos;
      r.status = ST_OK;
      r.line   = '0;
      case (kind)
         REQ_INSERT: begin
            pos = 0;
            while (pos < shadow_lines.size() && shadow_lines[pos] < line)
               pos++;
            if (line == '0)
               r.status = ST_INVALID;
            else if (pos < shadow_lines.size() && shadow_lines[pos] == line)
               r.status = ST_DUP;
            else if (shadow_lines.size() >= CAPACITY)
               r.status = ST_FULL;
            else
               shadow_lines.insert(pos, line);
         end
         REQ_CLEAR: shadow_lines.delete();
         REQ_READ: begin
            if (idx < shadow_lines.size())
               r.line = shadow_lines[idx];
            else
               r.status = ST_RANGE;
         end
         default: ;
      endcase
      r.count = slu_count_type'(shadow_lines.size());
      r.empty = (shadow_lines.size() == 0);
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(slu_req_type kind, slu_line_type line, logic [5:0] idx);
      start           <= 1'b1;
      req_type        <= kind;
      req_line_number <= line;
      req_read_index  <= idx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      results_due.push_back(predict_line_set(kind, line, idx));
      @(negedge clock);
   endtask

   task automatic paced_request(slu_req_type kind, slu_line_type line, logic [5:0] idx);
      int gap;
      send_request(kind, line, idx);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 25);
      end
   endtask

   task automatic hold_until_drained;
      start <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : check_responses
      line_set_result_type got;
      line_set_result_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_entry_line, rsp_entry_count, rsp_set_empty};
         if (results_due.size() == 0) begin
            $display("%0t: response with no request pending: status=%0d line=%h count=%0d empty=%0d",
                     $realtime, got.status, got.line, got.count, got.empty);
            error_count++;
         end else begin
            want = results_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected status=%0d line=%h count=%0d empty=%0d",
                        $realtime, want.status, want.line, want.count, want.empty);
               $display("%0t:          actual   status=%0d line=%h count=%0d empty=%0d",
                        $realtime, got.status, got.line, got.count, got.empty);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_cases;
      send_request(REQ_READ, '0, '0);
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_INSERT, 20'hFFFFF, 6'h3F);
      send_request(REQ_INSERT, 20'h00001, '0);
      send_request(REQ_INSERT, 20'h00001, '0);
      send_request(REQ_INSERT, 20'h80000, '0);
      send_request(REQ_INSERT, 20'h55555, '0);
      send_request(REQ_INSERT, 20'hAAAAA, '0);
      for (int i = 0; i < 6; i++)
         send_request(REQ_READ, '0, i[5:0]);
      send_request(REQ_READ, 20'hFFFFF, 6'h3F);
      send_request(REQ_NONE, 20'hFFFFF, 6'h3F);
      send_request(REQ_CLEAR, 20'hFFFFF, 6'h3F);
      send_request(REQ_READ, '0, '0);
      send_request(REQ_CLEAR, '0, '0);
      send_request(REQ_INSERT, 20'h00007, '0);
      hold_until_drained();
   endtask

   // fill to capacity with values inside the range, then push new values at both ends, duplicates and zero
   task automatic test_capacity_limit;
      send_request(REQ_CLEAR, '0, '0);
      while (shadow_lines.size() < CAPACITY)
         paced_request(REQ_INSERT, slu_line_type'($urandom_range(2, 20'hFFFFE)),
                       6'($urandom));
      send_request(REQ_INSERT, 20'h00001, '0);
      send_request(REQ_INSERT, 20'hFFFFF, '0);
      send_request(REQ_INSERT, shadow_lines[$urandom_range(0, CAPACITY - 1)], '0);
      send_request(REQ_INSERT, shadow_lines[0], '0);
      send_request(REQ_INSERT, shadow_lines[CAPACITY - 1], '0);
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_READ, '0, '0);
      send_request(REQ_READ, '0, 6'(CAPACITY - 1));
      hold_until_drained();
      send_request(REQ_CLEAR, '0, '0);
   endtask

   // even rounds lean on inserts and never clear, odd rounds mix in clears
   task automatic test_random_traffic;
      int           roll;
      int           pick;
      int           insert_pct;
      int           clear_pct;
      slu_req_type  kind;
      slu_line_type line;
      logic [5:0]   idx;
      for (int round = 0; round < 4; round++) begin
         insert_pct = (round % 2 == 0) ? 70 : 45;
         clear_pct  = (round % 2 == 0) ? 0 : 3;
         for (int n = 0; n < 190; n++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            line = slu_line_type'($urandom);
            idx  = 6'($urandom);
            if (roll < insert_pct) begin
               kind = REQ_INSERT;
               if (pick < 5)
                  line = '0;
               else if (pick < 40 && shadow_lines.size() != 0)
                  line = shadow_lines[$urandom_range(0, shadow_lines.size() - 1)];
               else if (pick < 65)
                  line = slu_line_type'($urandom_range(1, 255));
            end else if (roll < 92) begin
               kind = REQ_READ;
               if (pick < 80 && shadow_lines.size() != 0)
                  idx = 6'($urandom_range(0, shadow_lines.size() - 1));
            end else if (roll < 96) begin
               kind = REQ_NONE;
            end else if (roll < 96 + clear_pct) begin
               kind = REQ_CLEAR;
            end else begin
               kind = REQ_READ;
            end
            paced_request(kind, line, idx);
         end
         if (round == 1)
            hold_until_drained();
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_NONE;
      req_line_number = '0;
      req_read_index  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_capacity_limit();
      test_random_traffic();

      hold_until_drained();
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("sorted_unique_line_set_test: PASS");
      else
         $display("sorted_unique_line_set_test: FAIL");
      $finish;
   end

endmodule
